// ===== design/fcb_pkg.sv =====
// Shared types and constants for the four-round Feistel block cipher.
// Used by the front end, the round engine and the top level.
package fcb_pkg;

	localparam int WORD_W      = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int TABLE_DEPTH = 1042;
	localparam int NUM_SUBKEYS = 6;
	localparam int SBOX_BASE   = 'h12;
	localparam int SBOX_DEPTH  = 256;
	localparam int NUM_SBOXES  = 4;
	localparam int SBOX_IDX_W  = $clog2(SBOX_DEPTH);
	localparam int TAB_ADDR_W  = $clog2(SBOX_DEPTH * NUM_SBOXES);
	localparam int SUBKEY_W    = $clog2(NUM_SUBKEYS);

	// Command codes on the input channel
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_ENC  = 2'd1;
	localparam logic [1:0] CMD_DEC  = 2'd2;

	// Classified operation carried from front end to round engine
	typedef enum logic [1:0] {
		OP_LOAD_SUB  = 2'd0,
		OP_LOAD_SBOX = 2'd1,
		OP_ENC       = 2'd2,
		OP_DEC       = 2'd3
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic [TAB_ADDR_W-1:0]   addr;  // subkey slot or S-box word position
		logic [WORD_W-1:0]       w0;    // first block word, or table word on a load
		logic [WORD_W-1:0]       w1;
		logic                    last;
	} item_t;

endpackage

// ===== design/fcb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fcb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, register one read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/fcb_front.sv =====
// Front end: accepts commands, classifies them and holds them in a short queue.
// Depends on fcb_pkg.
module fcb_front #(
	parameter int QUEUE_DEPTH = fcb_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  command,
	input  logic [10:0]                 key_index,
	input  logic [fcb_pkg::WORD_W-1:0]  key_word,
	input  logic [fcb_pkg::WORD_W-1:0]  first_word,
	input  logic [fcb_pkg::WORD_W-1:0]  second_word,
	input  logic                        last_block,
	output fcb_pkg::item_t              head,
	output logic                        head_valid,
	input  logic                        pop
);
	import fcb_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             item;
	logic              keep;
	logic [10:0]       sbox_off;
	logic              push;
	item_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign sbox_off = key_index - 11'(SBOX_BASE);

	// Classify the command; drop loads to unused or absent words and the spare code
	always_comb begin
		keep      = 1'b0;
		item.op   = OP_ENC;
		item.addr = sbox_off[TAB_ADDR_W-1:0];
		item.w0   = first_word;
		item.w1   = second_word;
		item.last = last_block;
		unique case (command)
			CMD_LOAD: begin
				item.w0 = key_word;
				if (key_index < 11'(NUM_SUBKEYS)) begin
					keep      = 1'b1;
					item.op   = OP_LOAD_SUB;
					item.addr = key_index[TAB_ADDR_W-1:0];
				end else if (key_index >= 11'(SBOX_BASE) && key_index < 11'(TABLE_DEPTH)) begin
					keep    = 1'b1;
					item.op = OP_LOAD_SBOX;
				end
			end
			CMD_ENC: begin
				keep    = 1'b1;
				item.op = OP_ENC;
			end
			CMD_DEC: begin
				keep    = 1'b1;
				item.op = OP_DEC;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign busy       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push       = start && !busy && keep;
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

	// Queue control: advance pointers and fill count on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= item;
		end
	end

endmodule

// ===== design/fcb_back.sv =====
// Round engine: executes table loads and runs four Feistel rounds per block.
// Depends on fcb_pkg and fcb_ram (four S-box memories).
module fcb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fcb_pkg::item_t              head,
	input  logic                        head_valid,
	output logic                        pop,
	output logic                        done,
	output logic [fcb_pkg::WORD_W-1:0]  out_first_word,
	output logic [fcb_pkg::WORD_W-1:0]  out_second_word,
	output logic                        out_last
);
	import fcb_pkg::*;

	logic                 active_q;
	logic [1:0]           rnd_q;
	logic                 dec_q;
	logic                 done_q;
	logic [WORD_W-1:0]    left_q;
	logic [WORD_W-1:0]    right_q;
	logic [WORD_W-1:0]    sk_q [NUM_SUBKEYS];
	logic [WORD_W-1:0]    first_q;
	logic [WORD_W-1:0]    second_q;
	logic                 last_q;
	logic                 out_last_q;

	logic                 is_block;
	logic                 issue_block;
	logic [SUBKEY_W-1:0]  rkey_idx;
	logic [WORD_W-1:0]    first_key;
	logic [WORD_W-1:0]    round_key;
	logic [WORD_W-1:0]    last_key;
	logic [WORD_W-1:0]    sbox_data [NUM_SBOXES];
	logic [WORD_W-1:0]    f_val;
	logic [WORD_W-1:0]    x_val;
	logic [WORD_W-1:0]    new_left;
	logic [WORD_W-1:0]    new_right;
	logic [WORD_W-1:0]    init_left;
	logic [WORD_W-1:0]    look_val;

	// Take the next item when idle or in the last round of a block
	assign pop         = head_valid && (!active_q || rnd_q == 2'd3);
	assign is_block    = (head.op == OP_ENC) || (head.op == OP_DEC);
	assign issue_block = pop && is_block;

	// Subkey order: forward for encrypt, reversed for decrypt
	assign first_key = (head.op == OP_DEC) ? sk_q[NUM_SUBKEYS-1] : sk_q[0];
	assign rkey_idx  = dec_q ? SUBKEY_W'(3'd4 - {1'b0, rnd_q}) : SUBKEY_W'({1'b0, rnd_q} + 3'd1);
	assign round_key = sk_q[rkey_idx];
	assign last_key  = dec_q ? sk_q[0] : sk_q[NUM_SUBKEYS-1];

	// Round function on the registered S-box words
	assign f_val     = ((sbox_data[0] + sbox_data[1]) ^ sbox_data[2]) + sbox_data[3];
	assign x_val     = f_val ^ round_key;
	assign new_left  = left_q ^ x_val;
	assign new_right = right_q ^ x_val;
	assign init_left = head.w0 ^ first_key;

	// Half that feeds the next lookup
	assign look_val = issue_block ? init_left : (rnd_q[0] ? new_left : new_right);

	// S-box memories, one byte of the lookup value each
	for (genvar i = 0; i < NUM_SBOXES; i++) begin : g_sbox
		logic we;
		assign we = pop && (head.op == OP_LOAD_SBOX) &&
			(head.addr[TAB_ADDR_W-1:SBOX_IDX_W] == (TAB_ADDR_W - SBOX_IDX_W)'(i));
		fcb_ram #(
			.WIDTH (WORD_W),
			.DEPTH (SBOX_DEPTH)
		) u_sbox (
			.clk   (clk),
			.we    (we),
			.waddr (head.addr[SBOX_IDX_W-1:0]),
			.wdata (head.w0),
			.raddr (look_val[WORD_W-1-SBOX_IDX_W*i -: SBOX_IDX_W]),
			.rdata (sbox_data[i])
		);
	end

	// Round sequencing and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			rnd_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= active_q && (rnd_q == 2'd3);
			if (active_q && rnd_q != 2'd3) begin
				rnd_q <= rnd_q + 1'b1;
			end else if (issue_block) begin
				active_q <= 1'b1;
				rnd_q    <= '0;
			end else begin
				active_q <= 1'b0;
			end
		end
	end

	// Block halves, subkeys and result words
	always_ff @(posedge clk) begin
		if (issue_block) begin
			left_q  <= init_left;
			right_q <= head.w1;
			dec_q   <= (head.op == OP_DEC);
			last_q  <= head.last;
		end else if (active_q) begin
			if (rnd_q[0]) begin
				left_q <= new_left;
			end else begin
				right_q <= new_right;
			end
		end
		if (pop && head.op == OP_LOAD_SUB) begin
			sk_q[head.addr[SUBKEY_W-1:0]] <= head.w0;
		end
		if (active_q && rnd_q == 2'd3) begin
			first_q    <= right_q ^ last_key;
			second_q   <= new_left;
			out_last_q <= last_q;
		end
	end

	assign done            = done_q;
	assign out_first_word  = first_q;
	assign out_second_word = second_q;
	assign out_last        = out_last_q;

endmodule

// ===== design/feistel_four_round_block_cipher.sv =====
// Four-round Feistel block cipher with a loadable key table.
// Depends on fcb_pkg, fcb_front and fcb_back.
//
// Usage:
//   Present a command with start high; it transfers at a rising edge with
//   start high and busy low. Command load writes one key table word and
//   gives no result; encrypt and decrypt each give one result block.
//   Loads to words 6..17, loads beyond the table and the spare code are dropped.
//   Commands are queued (QUEUE_DEPTH entries) in front of the round engine,
//   so busy rises only when that queue is full.
//   A result appears for exactly one cycle with done high; the receiver cannot
//   stall, so results are never held back.
// Sequencing:
//   A block leaves the queue and then runs four rounds, each set by a read of
//   the four S-box memories; done follows the last round. The engine takes
//   the next item from the queue in the last round of a block, so a new block
//   can start without a gap; a load is executed as it leaves the queue.
// Reset:
//   arst_n clears the queue and engine control; table contents are undefined
//   until loaded.
module feistel_four_round_block_cipher #(
	parameter int QUEUE_DEPTH = fcb_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  command,
	input  logic [10:0]                 key_index,
	input  logic [fcb_pkg::WORD_W-1:0]  key_word,
	input  logic [fcb_pkg::WORD_W-1:0]  first_word,
	input  logic [fcb_pkg::WORD_W-1:0]  second_word,
	input  logic                        last_block,
	output logic                        done,
	output logic [fcb_pkg::WORD_W-1:0]  out_first_word,
	output logic [fcb_pkg::WORD_W-1:0]  out_second_word,
	output logic                        out_last
);
	import fcb_pkg::*;

	item_t head;
	logic  head_valid;
	logic  pop;

	fcb_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.key_index   (key_index),
		.key_word    (key_word),
		.first_word  (first_word),
		.second_word (second_word),
		.last_block  (last_block),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop)
	);

	fcb_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.head_valid      (head_valid),
		.pop             (pop),
		.done            (done),
		.out_first_word  (out_first_word),
		.out_second_word (out_second_word),
		.out_last        (out_last)
	);

endmodule

// ===== verif/tb_feistel_four_round_block_cipher.sv =====
// Testbench for the four-round Feistel block cipher: fills the key table, then runs
// directed and random command traffic against an in-bench cipher predictor.
// Depends on fcb_pkg and feistel_four_round_block_cipher.
module tb_feistel_four_round_block_cipher;
	import fcb_pkg::*;

	localparam logic [1:0] CMD_SPARE   = 2'd3;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         RANDOM_ITEMS = 450;
	localparam int         UNUSED_LO   = NUM_SUBKEYS;
	localparam int         UNUSED_HI   = SBOX_BASE - 1;

	typedef struct {
		logic [WORD_W-1:0] first_w;
		logic [WORD_W-1:0] second_w;
		logic              last_flag;
	} cipher_block_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        command;
	logic [10:0]       key_index;
	logic [WORD_W-1:0] key_word;
	logic [WORD_W-1:0] first_word;
	logic [WORD_W-1:0] second_word;
	logic              last_block;
	logic              done;
	logic [WORD_W-1:0] out_first_word;
	logic [WORD_W-1:0] out_second_word;
	logic              out_last;

	// Predictor copy of the key table and the blocks still owed by the cipher
	logic [WORD_W-1:0] cipher_tab [TABLE_DEPTH];
	cipher_block_t     owed_blocks [$];
	int                err_count = 0;
	int                run_cycles = 0;
	bit                idle_off = 1'b0;

	feistel_four_round_block_cipher u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.key_index       (key_index),
		.key_word        (key_word),
		.first_word      (first_word),
		.second_word     (second_word),
		.last_block      (last_block),
		.done            (done),
		.out_first_word  (out_first_word),
		.out_second_word (out_second_word),
		.out_last        (out_last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Round function: four S-box lookups mixed by add, xor, add
	function automatic logic [WORD_W-1:0] sbox_mix(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] a, b, c, d;
		a = cipher_tab[SBOX_BASE + int'(x[31:24])];
		b = cipher_tab[SBOX_BASE + SBOX_DEPTH + int'(x[23:16])];
		c = cipher_tab[SBOX_BASE + 2 * SBOX_DEPTH + int'(x[15:8])];
		d = cipher_tab[SBOX_BASE + 3 * SBOX_DEPTH + int'(x[7:0])];
		return ((a + b) ^ c) + d;
	endfunction

	// Four Feistel rounds; decrypt walks the subkeys in reverse
	function automatic cipher_block_t feistel_rounds(input logic [WORD_W-1:0] w0,
			input logic [WORD_W-1:0] w1, input logic decrypt, input logic lb);
		cipher_block_t     res;
		int                sk [NUM_SUBKEYS];
		logic [WORD_W-1:0] l, r, t;
		for (int i = 0; i < NUM_SUBKEYS; i++) begin
			sk[i] = decrypt ? NUM_SUBKEYS - 1 - i : i;
		end
		l = w0 ^ cipher_tab[sk[0]];
		r = sbox_mix(l) ^ cipher_tab[sk[1]] ^ w1;
		l ^= sbox_mix(r) ^ cipher_tab[sk[2]];
		r ^= sbox_mix(l) ^ cipher_tab[sk[3]];
		t = sbox_mix(r) ^ cipher_tab[sk[4]];
		res.first_w   = r ^ cipher_tab[sk[5]];
		res.second_w  = l ^ t;
		res.last_flag = lb;
		return res;
	endfunction

	// Check each result against the oldest owed block, then predict any new transfer
	always @(posedge clk) begin : track_cipher
		cipher_block_t want;
		if (arst_n && done) begin
			if (owed_blocks.size() == 0) begin
				if (err_count < 10)
					$display("ERROR: result %h %h last %b with none owed",
						out_first_word, out_second_word, out_last);
				err_count++;
			end else begin
				want = owed_blocks.pop_front();
				if (out_first_word !== want.first_w || out_second_word !== want.second_w
						|| out_last !== want.last_flag) begin
					if (err_count < 10)
						$display("ERROR: block exp %h %h last %b, got %h %h last %b",
							want.first_w, want.second_w, want.last_flag,
							out_first_word, out_second_word, out_last);
					err_count++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			case (command)
				CMD_LOAD: begin
					if (key_index < TABLE_DEPTH)
						cipher_tab[key_index] = key_word;
				end
				CMD_ENC: owed_blocks.push_back(feistel_rounds(first_word, second_word,
					1'b0, last_block));
				CMD_DEC: owed_blocks.push_back(feistel_rounds(first_word, second_word,
					1'b1, last_block));
				default: ;
			endcase
		end
	end

	// Watchdog on total run length
	always @(posedge clk) begin
		run_cycles++;
		if (run_cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Present one command after a random gap and hold it until it transfers
	task automatic send_item(input logic [1:0] cmd, input logic [10:0] idx,
			input logic [WORD_W-1:0] kw, input logic [WORD_W-1:0] w0,
			input logic [WORD_W-1:0] w1, input logic lb);
		int gap;
		gap = idle_off ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start       <= 1'b1;
		command     <= cmd;
		key_index   <= idx;
		key_word    <= kw;
		first_word  <= w0;
		second_word <= w1;
		last_block  <= lb;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic load_word(input int idx, input logic [WORD_W-1:0] word);
		send_item(CMD_LOAD, idx[10:0], word, $urandom, $urandom, 1'($urandom));
	endtask

	task automatic send_block(input logic [1:0] cmd, input logic [WORD_W-1:0] w0,
			input logic [WORD_W-1:0] w1, input logic lb);
		send_item(cmd, 11'($urandom_range(0, 2047)), $urandom, w0, w1, lb);
	endtask

	task automatic stop_driving();
		@(negedge clk);
		start <= 1'b0;
	endtask

	// Load every subkey and S-box word so that no block reads an unwritten entry
	task automatic fill_key_table();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (i < UNUSED_LO || i > UNUSED_HI)
				load_word(i, $urandom);
		end
	endtask

	task automatic test_block_extremes();
		send_block(CMD_ENC, 32'h0000_0000, 32'h0000_0000, 1'b0);
		send_block(CMD_ENC, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
		send_block(CMD_DEC, 32'h0000_0000, 32'hffff_ffff, 1'b1);
		send_block(CMD_DEC, 32'hffff_ffff, 32'h0000_0000, 1'b0);
		send_block(CMD_ENC, 32'haaaa_aaaa, 32'h5555_5555, 1'b0);
		send_block(CMD_DEC, 32'h5555_5555, 32'haaaa_aaaa, 1'b1);
	endtask

	// Rewrite the outer subkeys and the S-box ends, then use them at once
	task automatic test_key_reload();
		load_word(0, 32'hffff_ffff);
		load_word(NUM_SUBKEYS - 1, 32'h0000_0000);
		load_word(SBOX_BASE, 32'h0000_0000);
		load_word(TABLE_DEPTH - 1, 32'hffff_ffff);
		send_block(CMD_ENC, 32'hffff_ffff, 32'h0000_00ff, 1'b1);
		send_block(CMD_DEC, 32'h0000_00ff, 32'hffff_ffff, 1'b0);
	endtask

	// Spare code, loads past the table and loads to the unused words change nothing
	task automatic test_ignored_commands();
		send_item(CMD_SPARE, 11'($urandom_range(0, 2047)), $urandom, $urandom, $urandom,
			1'b1);
		send_item(CMD_SPARE, 11'h7ff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
		load_word(TABLE_DEPTH, $urandom);
		load_word(2047, 32'hffff_ffff);
		load_word(UNUSED_LO, $urandom);
		load_word(UNUSED_HI, $urandom);
		send_block(CMD_ENC, $urandom, $urandom, 1'b1);
	endtask

	// Burst blocks back to back, let the cipher drain fully, then resume
	task automatic test_pause_until_drained();
		idle_off = 1'b1;
		for (int i = 0; i < 8; i++)
			send_block((i % 2) ? CMD_DEC : CMD_ENC, $urandom, $urandom, 1'($urandom));
		idle_off = 1'b0;
		stop_driving();
		while (owed_blocks.size() != 0) @(posedge clk);
		for (int i = 0; i < 4; i++)
			send_block(CMD_ENC, $urandom, $urandom, 1'($urandom));
	endtask

	// Mostly blocks, with live key reloads, stray loads and spare codes mixed in
	task automatic test_random_traffic();
		int pick;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				idle_off = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_block(CMD_ENC, $urandom, $urandom, 1'($urandom));
			else if (pick < 80)
				send_block(CMD_DEC, $urandom, $urandom, 1'($urandom));
			else if (pick < 88)
				load_word($urandom_range(0, TABLE_DEPTH - 1), $urandom);
			else if (pick < 93)
				load_word($urandom_range(0, 2047), $urandom);
			else
				send_item(CMD_SPARE, 11'($urandom_range(0, 2047)), $urandom, $urandom,
					$urandom, 1'($urandom));
		end
		idle_off = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		command     = CMD_LOAD;
		key_index   = '0;
		key_word    = '0;
		first_word  = '0;
		second_word = '0;
		last_block  = 1'b0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			cipher_tab[i] = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		fill_key_table();
		test_block_extremes();
		test_key_reload();
		test_ignored_commands();
		test_pause_until_drained();
		test_random_traffic();

		// Drain, then allow a few more cycles for any stray result
		stop_driving();
		while (owed_blocks.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/fcb_pkg.sv
design/fcb_ram.sv
design/fcb_front.sv
design/fcb_back.sv
design/feistel_four_round_block_cipher.sv
verif/tb_feistel_four_round_block_cipher.sv
